FILE: hdl/avre_pkg.sv
// shared types and constants for the ack vector run-length encoder
// request payload structs, operation codes and register indexes
// no dependencies
package avre_pkg;

    // run field mask of a vector byte
    localparam logic [5:0] RUN_MAX = 6'h3F;

    // register indexes on the configuration port
    localparam logic REG_MAX_VECTOR_BYTES  = 1'b0;
    localparam logic REG_NOT_RECEIVED_CODE = 1'b1;

    // reset values of the registers
    localparam logic [6:0] MAX_VECTOR_BYTES_RESET  = 7'd127;
    localparam logic [1:0] NOT_RECEIVED_CODE_RESET = 2'd0;

    // operation codes; the fourth code is unused
    typedef enum logic [1:0] {
        OP_START    = 2'd0,
        OP_ADD      = 2'd1,
        OP_FINALIZE = 2'd2
    } t_avre_op;

    // input request
    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] gsnr_value;
        logic [63:0] gsnfr_value;
        logic        start_parity;
        logic [1:0]  packet_state;
        logic        packet_parity;
    } t_avre_in;

    // result request
    typedef struct packed {
        logic       accepted;
        logic [6:0] byte_index;
        logic [7:0] byte_value;
        logic       parity_out;
        logic [6:0] vector_length;
    } t_avre_out;

    // configuration values seen by the encoder
    typedef struct packed {
        logic [6:0] max_vector_bytes;
        logic [1:0] not_received_code;
    } t_avre_cfg;

endpackage

FILE: hdl/avre_cfg.sv
// configuration registers of the ack vector encoder behind an apb-style port
// depends on avre_pkg
module avre_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output avre_pkg::t_avre_cfg o_cfg
);
    import avre_pkg::*;

    logic [6:0] r_max_bytes;
    logic [1:0] r_nr_code;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes, word select on address bit 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= MAX_VECTOR_BYTES_RESET;
            r_nr_code   <= NOT_RECEIVED_CODE_RESET;
        end else if (wr_en) begin
            if (paddr[2] == REG_MAX_VECTOR_BYTES) begin
                r_max_bytes <= pwdata[6:0];
            end else begin
                r_nr_code <= pwdata[1:0];
            end
        end
    end

    // read back, low byte lanes ignored
    always_comb begin
        if (paddr[2] == REG_NOT_RECEIVED_CODE) begin
            prdata = {30'd0, r_nr_code};
        end else begin
            prdata = {25'd0, r_max_bytes} | {29'd0, paddr[1:0], 1'b0} & 32'd0;
        end
    end

    assign o_cfg.max_vector_bytes  = r_max_bytes;
    assign o_cfg.not_received_code = r_nr_code;

endmodule

FILE: hdl/avre_core.sv
// encoder state and single-pass update logic for one request
// depends on avre_pkg
module avre_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  avre_pkg::t_avre_in  i_item,
    input  avre_pkg::t_avre_cfg i_cfg,
    output avre_pkg::t_avre_out o_res
);
    import avre_pkg::*;

    logic [63:0] r_seq, n_seq;
    logic [63:0] r_limit, n_limit;
    logic [63:0] r_first, n_first;
    logic [6:0]  r_filled, n_filled;
    logic [1:0]  r_last, n_last;
    logic [7:0]  r_byte, n_byte;
    logic        r_parity, n_parity;

    logic [63:0] seq_inc;
    logic        in_range;
    logic        open_new;
    logic        room;
    logic        counts;
    t_avre_out   res;

    assign seq_inc  = r_seq + 64'd1;
    assign in_range = seq_inc < r_limit;
    assign counts   = i_item.packet_state != i_cfg.not_received_code;

    // a new byte opens on an empty vector, a state change or a full run
    assign open_new = (r_filled == 7'd0) || (r_last != i_item.packet_state)
                      || (r_byte[5:0] == RUN_MAX);
    assign room     = (r_filled == 7'd0) ? (i_cfg.max_vector_bytes != 7'd0)
                                         : (r_filled < i_cfg.max_vector_bytes);

    // next state and result
    always_comb begin
        n_seq    = r_seq;
        n_limit  = r_limit;
        n_first  = r_first;
        n_filled = r_filled;
        n_last   = r_last;
        n_byte   = r_byte;
        n_parity = r_parity;
        res      = '0;
        unique case (i_item.operation)
            OP_START: begin
                n_limit  = i_item.gsnr_value;
                n_first  = i_item.gsnfr_value;
                n_seq    = i_item.gsnfr_value;
                n_parity = i_item.start_parity;
                n_filled = 7'd0;
                n_byte   = 8'd0;
                n_last   = 2'd0;
            end
            OP_ADD: begin
                n_seq = seq_inc;
                if (in_range) begin
                    if (open_new) begin
                        if (room) begin
                            n_byte         = {i_item.packet_state, 6'd1};
                            n_last         = i_item.packet_state;
                            n_filled       = r_filled + 7'd1;
                            n_parity       = r_parity ^ (counts & i_item.packet_parity);
                            res.accepted   = 1'b1;
                            res.byte_index = r_filled;
                            res.byte_value = {i_item.packet_state, 6'd1};
                        end
                    end else begin
                        n_byte         = {r_byte[7:6], r_byte[5:0] + 6'd1};
                        n_parity       = r_parity ^ (counts & i_item.packet_parity);
                        res.accepted   = 1'b1;
                        res.byte_index = r_filled - 7'd1;
                        res.byte_value = {r_byte[7:6], r_byte[5:0] + 6'd1};
                    end
                end
            end
            OP_FINALIZE: begin
                res.parity_out = r_parity;
                if ((r_filled != 7'd0) && (r_first != r_limit) &&
                    !((r_filled == 7'd1) && (r_last == i_cfg.not_received_code))) begin
                    res.vector_length = r_filled;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res = res;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq    <= '0;
            r_limit  <= '0;
            r_first  <= '0;
            r_filled <= '0;
            r_last   <= '0;
            r_byte   <= '0;
            r_parity <= 1'b0;
        end else if (i_step) begin
            r_seq    <= n_seq;
            r_limit  <= n_limit;
            r_first  <= n_first;
            r_filled <= n_filled;
            r_last   <= n_last;
            r_byte   <= n_byte;
            r_parity <= n_parity;
        end
    end

    // a refused add leaves the vector untouched
    a_refused_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (i_item.operation == OP_ADD) && !res.accepted
        |=> $stable(r_filled) && $stable(r_byte) && $stable(r_parity))
        else $error("refused add changed the vector");

    // every encoded byte carries a nonzero run
    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.accepted |-> (res.byte_value[5:0] != 6'd0))
        else $error("encoded byte with empty run");

    // opening a byte never moves past capacity
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && res.accepted && open_new
        |=> (r_filled <= $past(i_cfg.max_vector_bytes)))
        else $error("vector grew past capacity");

endmodule

FILE: hdl/ack_vector_rle_encoder_core.sv
// ack vector run-length encoder
// Requests enter on the input channel (i_in_valid, o_in_stall, i_in_data) and
// are taken at a clock edge with valid high and stall low. Each request gives
// exactly one result on the output channel (o_out_valid, i_out_stall,
// o_out_data), in order.
// An accepted request sits in the input register, where the encoder updates
// its state and computes the result, which is written to the output register.
// One request per cycle is sustained while the receiver does not stall; the
// path between the two registers is one 64-bit increment and compare against
// the received limit. When the receiver stalls, the result holds in the
// output register and the next request waits in the input register; only
// then is o_in_stall raised. Reset (i_rst_n low, synchronous) empties both
// registers, clears the vector state and restores capacity 127 and
// not-received code 0. The user must write configuration over the apb port
// only while no request is in flight; the core does not enforce this.
// depends on avre_pkg, avre_cfg, avre_core
module ack_vector_rle_encoder_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  avre_pkg::t_avre_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output avre_pkg::t_avre_out o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import avre_pkg::*;

    logic      r_in_valid;
    t_avre_in  r_in_data;
    logic      r_out_valid;
    t_avre_out r_out_data;
    logic      out_free;
    logic      step;
    t_avre_cfg cfg;
    t_avre_out res;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // configuration registers
    avre_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // encoder state and update
    avre_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in_data),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_data <= i_in_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // a waiting request is never dropped while the output is blocked
    a_hold_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_free |=> r_in_valid && $stable(r_in_data))
        else $error("waiting request lost");

    // a stepped request always lands in the output register
    a_step_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("result not registered");

    // stall is raised only with a request held and the output blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("spurious input stall");

endmodule

FILE: verif/testbench.sv
// self-checking testbench for the ack vector run-length encoder core
// drives requests and apb register writes, predicts each result and checks it
// depends on avre_pkg and ack_vector_rle_encoder_core
`timescale 1ns / 1ps

module testbench;
    import avre_pkg::*;

    // the one operation code the package leaves unnamed
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD = 300;
    localparam int PHASE_ITEMS = 240;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_avre_in    in_data = '0;
    logic        out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire         o_in_stall;
    wire         o_out_valid;
    t_avre_out   o_out_data;
    wire  [31:0] prdata;
    wire         pready;

    ack_vector_rle_encoder_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // clock
    always #10 i_clk = ~i_clk;

    // predictor copy of the registers and the vector state
    logic [6:0]  cap_bytes = MAX_VECTOR_BYTES_RESET;
    logic [1:0]  missing_code = NOT_RECEIVED_CODE_RESET;
    logic [63:0] seq_now = '0;
    logic [63:0] seq_limit = '0;
    logic [63:0] seq_first_missing = '0;
    logic [6:0]  bytes_used = '0;
    logic [1:0]  run_code = '0;
    logic [7:0]  run_byte = '0;
    logic        parity_acc = 1'b0;

    t_avre_in  pending_requests[$];
    t_avre_out predicted_results[$];
    int requests_sent = 0;
    int requests_taken = 0;
    int mismatch_count = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int idle_cycles = 0;
    bit quiet = 1'b0;

    // one line per mismatch, printing capped so a broken block stays readable
    task automatic note_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        if (mismatch_count < 30)
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // compute the result of one request and advance the vector state
    task automatic encode_request(input t_avre_in req, output t_avre_out res);
        logic [1:0] code;
        logic       grow;
        logic       extend;
        code = req.packet_state;
        grow = 1'b0;
        extend = 1'b0;
        res = '0;
        case (req.operation)
            OP_START: begin
                seq_limit = req.gsnr_value;
                seq_first_missing = req.gsnfr_value;
                seq_now = req.gsnfr_value;
                parity_acc = req.start_parity;
                bytes_used = '0;
                run_byte = '0;
                run_code = '0;
            end
            OP_ADD: begin
                seq_now = seq_now + 64'd1;
                if (seq_now < seq_limit) begin
                    if (bytes_used == 7'd0)
                        grow = (cap_bytes != 7'd0);
                    else if (run_code != code || run_byte[5:0] == RUN_MAX)
                        grow = (bytes_used < cap_bytes);
                    else
                        extend = 1'b1;
                    if (grow) begin
                        run_byte = {code, 6'd1};
                        run_code = code;
                        bytes_used = bytes_used + 7'd1;
                    end else if (extend) begin
                        run_byte[5:0] = run_byte[5:0] + 6'd1;
                    end
                    if ((grow || extend) && code != missing_code)
                        parity_acc = parity_acc ^ req.packet_parity;
                    if (grow || extend) begin
                        res.accepted = 1'b1;
                        res.byte_index = bytes_used - 7'd1;
                        res.byte_value = run_byte;
                    end
                end
            end
            OP_FINALIZE: begin
                res.parity_out = parity_acc;
                if (bytes_used != 7'd0 && seq_first_missing != seq_limit &&
                    !(bytes_used == 7'd1 && run_code == missing_code))
                    res.vector_length = bytes_used;
            end
            default: ;
        endcase
    endtask

    // driver: offers queued requests, with random gaps between them
    always @(posedge i_clk) begin : drive_requests
        logic      taken;
        logic      next_valid;
        t_avre_out res;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            taken = in_valid && !o_in_stall;
            next_valid = in_valid && !taken;
            if (taken) begin
                encode_request(in_data, res);
                predicted_results.push_back(res);
                requests_taken++;
                if (!quiet && $urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(1, 18);
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_requests.size() > 0) begin
                    in_data <= pending_requests.pop_front();
                    next_valid = 1'b1;
                end
            end
            in_valid <= next_valid;
        end
    end

    // monitor: checks each result and drives the receiver stall
    always @(posedge i_clk) begin : watch_results
        t_avre_out want;
        logic      stall_next;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (predicted_results.size() == 0) begin
                    note_mismatch("result with nothing pending", o_out_data.byte_value, 8'h0);
                end else begin
                    want = predicted_results.pop_front();
                    if (o_out_data.accepted !== want.accepted)
                        note_mismatch("accepted", 8'(o_out_data.accepted),
                                      8'(want.accepted));
                    if (o_out_data.byte_index !== want.byte_index)
                        note_mismatch("byte_index", 8'(o_out_data.byte_index),
                                      8'(want.byte_index));
                    if (o_out_data.byte_value !== want.byte_value)
                        note_mismatch("byte_value", o_out_data.byte_value, want.byte_value);
                    if (o_out_data.parity_out !== want.parity_out)
                        note_mismatch("parity_out", 8'(o_out_data.parity_out),
                                      8'(want.parity_out));
                    if (o_out_data.vector_length !== want.vector_length)
                        note_mismatch("vector_length", 8'(o_out_data.vector_length),
                                      8'(want.vector_length));
                end
            end
            // long hold-off on request, else random stall bursts
            if (hold_seen != hold_token) begin
                hold_seen = hold_token;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                stall_next = 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                stall_next = 1'b1;
            end else begin
                stall_next = 1'b0;
            end
            out_stall <= stall_next;
        end
    end

    // watchdog on cycles without any accepted request or delivered result
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_avre_in random_request();
        t_avre_in r;
        r.operation = 2'($urandom_range(0, 3));
        r.gsnr_value = {$urandom, $urandom};
        r.gsnfr_value = {$urandom, $urandom};
        r.start_parity = 1'($urandom);
        r.packet_state = 2'($urandom);
        r.packet_parity = 1'($urandom);
        return r;
    endfunction

    task automatic push_request(input t_avre_in r);
        pending_requests.push_back(r);
        requests_sent++;
    endtask

    task automatic push_op(input logic [1:0] op, input logic [63:0] gsnr,
                           input logic [63:0] gsnfr, input logic sp,
                           input logic [1:0] state, input logic pp);
        t_avre_in r;
        r.operation = op;
        r.gsnr_value = gsnr;
        r.gsnfr_value = gsnfr;
        r.start_parity = sp;
        r.packet_state = state;
        r.packet_parity = pp;
        push_request(r);
    endtask

    // wait until every request is taken and every result checked
    task automatic wait_drained();
        while (requests_taken != requests_sent || predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // apb write, then read back
    task automatic write_register(input logic index, input logic [6:0] value);
        logic [31:0] want;
        want = (index == REG_MAX_VECTOR_BYTES) ? {25'd0, value} : {30'd0, value[1:0]};
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {index, 2'b00};
        pwdata <= (index == REG_MAX_VECTOR_BYTES) ? {25'($urandom), value}
                                                  : {30'($urandom), value[1:0]};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        penable <= 1'b0;
        if (index == REG_MAX_VECTOR_BYTES)
            cap_bytes = value;
        else
            missing_code = value[1:0];
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want)
            note_mismatch("register read", prdata[7:0], want[7:0]);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [6:0] cap, input logic [1:0] code);
        wait_drained();
        write_register(REG_MAX_VECTOR_BYTES, cap);
        write_register(REG_NOT_RECEIVED_CODE, {5'd0, code});
    endtask

    // one vector: start, a run-heavy stream of adds, usually a finalize
    task automatic queue_session(inout int count);
        t_avre_in r;
        int adds;
        logic [63:0] span;
        logic [1:0] state;
        adds = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 30);
        r = random_request();
        r.operation = OP_START;
        if ($urandom_range(0, 7) == 0)
            r.gsnfr_value = ALL_ONES - 64'($urandom_range(0, 20));
        case ($urandom_range(0, 15))
            0: span = 64'd0;
            1: span = {$urandom, $urandom};
            2: span = -64'($urandom_range(1, 5));
            default: span = 64'($urandom_range(1, adds + 10));
        endcase
        r.gsnr_value = r.gsnfr_value + span;
        push_request(r);
        count++;
        state = 2'($urandom);
        for (int k = 0; k < adds; k++) begin
            if ($urandom_range(0, 15) == 0)
                state = 2'($urandom);
            r = random_request();
            r.operation = OP_ADD;
            r.packet_state = state;
            push_request(r);
            count++;
            if ($urandom_range(0, 29) == 0) begin
                r = random_request();
                r.operation = OP_FINALIZE;
                push_request(r);
                count++;
            end
        end
        if ($urandom_range(0, 9) != 0) begin
            r = random_request();
            r.operation = OP_FINALIZE;
            push_request(r);
            count++;
        end
    endtask

    task automatic queue_random_phase(input int n);
        int count;
        count = 0;
        while (count < n) begin
            if ($urandom_range(0, 9) == 0) begin
                push_request(random_request());
                count++;
            end else begin
                queue_session(count);
            end
        end
    endtask

    // stimulus and end of run
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset state: adds refused, empty finalize, unused code
        push_op(OP_ADD, '0, '0, 1'b0, 2'd1, 1'b1);
        push_op(OP_FINALIZE, '0, '0, 1'b0, 2'd0, 1'b0);
        push_op(OP_UNUSED, ALL_ONES, ALL_ONES, 1'b1, 2'd3, 1'b1);
        // first-missing equals greatest received
        push_op(OP_START, 64'd5, 64'd5, 1'b1, 2'd0, 1'b0);
        push_op(OP_ADD, '0, '0, 1'b0, 2'd2, 1'b1);
        push_op(OP_FINALIZE, '0, '0, 1'b0, 2'd0, 1'b0);
        // wrap of the sequence number, one all-missing byte, then a run
        push_op(OP_START, 64'd3, ALL_ONES, 1'b0, 2'd0, 1'b0);
        push_op(OP_ADD, '0, '0, 1'b0, 2'd0, 1'b1);
        push_op(OP_FINALIZE, '0, '0, 1'b0, 2'd0, 1'b0);
        push_op(OP_ADD, '0, '0, 1'b0, 2'd3, 1'b1);
        push_op(OP_ADD, '0, '0, 1'b0, 2'd3, 1'b1);
        push_op(OP_ADD, '0, '0, 1'b0, 2'd3, 1'b1);
        push_op(OP_FINALIZE, '0, '0, 1'b0, 2'd0, 1'b0);
        // limit at the top of the number space
        push_op(OP_START, ALL_ONES, ALL_ONES - 64'd1, 1'b1, 2'd0, 1'b0);
        push_op(OP_ADD, '0, '0, 1'b0, 2'd2, 1'b1);
        push_op(OP_FINALIZE, '0, '0, 1'b0, 2'd0, 1'b0);
        push_op(OP_START, ALL_ONES, '0, 1'b0, 2'd0, 1'b0);
        push_op(OP_ADD, ALL_ONES, ALL_ONES, 1'b1, 2'd1, 1'b1);
        push_op(OP_ADD, '0, '0, 1'b0, 2'd1, 1'b1);
        push_op(OP_ADD, '0, '0, 1'b0, 2'd2, 1'b1);
        push_op(OP_ADD, '0, '0, 1'b0, 2'd2, 1'b0);
        push_op(OP_FINALIZE, ALL_ONES, ALL_ONES, 1'b1, 2'd3, 1'b1);
        push_op(OP_START, ALL_ONES, ALL_ONES, 1'b1, 2'd3, 1'b1);
        push_op(OP_FINALIZE, '0, '0, 1'b0, 2'd0, 1'b0);

        // zero capacity
        set_config(7'd0, 2'd3);
        queue_random_phase(PHASE_ITEMS / 2);

        // capacity of one byte, with a long receiver hold-off
        set_config(7'd1, 2'd2);
        queue_random_phase(PHASE_ITEMS);
        hold_token++;

        set_config(7'd3, 2'd1);
        queue_random_phase(PHASE_ITEMS);

        set_config(7'd127, 2'd3);
        queue_random_phase(PHASE_ITEMS);

        set_config(7'($urandom_range(0, 127)), 2'($urandom));
        queue_random_phase(PHASE_ITEMS / 2);

        // last part without idling on either side
        set_config(7'd127, 2'd0);
        quiet = 1'b1;
        queue_random_phase(PHASE_ITEMS);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
